/* rtl/acf_pkg.sv */
`default_nettype none
package acf_pkg;

  // fixed-point layout
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int STATE_FRAC      = 16;
  localparam int PRESCALE        = 14;

  localparam int STEP_W   = $clog2(CORDIC_STEPS);
  localparam int CNT_W    = $clog2(CORDIC_STEPS);

  localparam int CW    = 33;  // cordic x/y
  localparam int ZW    = 26;  // angle accumulators, degrees q.16
  localparam int EW    = 25;  // stored estimates
  localparam int MAGW  = 31;
  localparam int RMAGW = 30;
  localparam int PW    = 32;  // |rate| * dt
  localparam int NW    = 49;  // dividend
  localparam int QW    = 22;  // gyro quotient
  localparam int RPW   = PW + QW;  // reciprocal product
  localparam int RW    = 29;  // remainder after the estimate
  localparam int GW    = 43;  // alpha * g
  localparam int AW    = 44;  // (1 - alpha) * acc
  localparam int SW    = 45;  // blend sum

  localparam logic signed [ZW-1:0] DEG180    = ZW'(180 * 65536);
  localparam logic [RMAGW-1:0]     INV_GAIN  = RMAGW'(652032875);
  localparam logic [NW-1:0]        DIV_RND   = NW'(65500000);
  // floor(2^48 / 131000000), estimate is low by at most two
  localparam logic [QW-1:0]        DIV_RECIP = QW'(2148663);
  localparam logic [NW-1:0]        DIV_DEN   = NW'(131000000);
  localparam logic [RW-1:0]        DIV_DEN1  = RW'(131000000);
  localparam logic [RW-1:0]        DIV_DEN2  = RW'(262000000);
  localparam int                   ANG_LIM   =
    ((180 << ANGLE_FRAC_BITS) > 32767) ? 32767 : (180 << ANGLE_FRAC_BITS);

  typedef enum logic [1:0] {
    CFG_ALPHA  = 2'd0,
    CFG_BIAS_X = 2'd1,
    CFG_BIAS_Y = 2'd2,
    CFG_FLOOR  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CORD1, S_GAIN, S_LOAD2, S_CORD2, S_GYRO, S_DINIT, S_DIV, S_DFIX,
    S_BLEND_G, S_BLEND_A, S_UPDATE, S_EMIT
  } state_t;

  typedef struct packed {
    logic              in_load;
    logic              cord_step;
    logic [STEP_W-1:0] step;
    logic              gain;
    logic              load2;
    logic              gyro;
    logic              div_init;
    logic              div_step;
    logic              div_fix;
    logic              blend_g;
    logic              blend_a;
    logic              update;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic thr_ok;
    logic out_free;
  } sts_t;

  // atan(2^-i) in degrees q.16
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = ZW'(2949120);
      5'd1:  v = ZW'(1740967);
      5'd2:  v = ZW'(919879);
      5'd3:  v = ZW'(466945);
      5'd4:  v = ZW'(234379);
      5'd5:  v = ZW'(117304);
      5'd6:  v = ZW'(58666);
      5'd7:  v = ZW'(29335);
      5'd8:  v = ZW'(14668);
      5'd9:  v = ZW'(7334);
      5'd10: v = ZW'(3667);
      5'd11: v = ZW'(1833);
      5'd12: v = ZW'(917);
      5'd13: v = ZW'(458);
      5'd14: v = ZW'(229);
      5'd15: v = ZW'(115);
      5'd16: v = ZW'(57);
      5'd17: v = ZW'(29);
      5'd18: v = ZW'(14);
      5'd19: v = ZW'(7);
      5'd20: v = ZW'(4);
      5'd21: v = ZW'(2);
      5'd22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/acf_in_if.sv */
`default_nettype none
interface acf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] accel_x;
  logic [15:0] accel_y;
  logic [15:0] accel_z;
  logic [15:0] rate_x;
  logic [15:0] rate_y;
  logic [15:0] elapsed_us;
  logic [9:0]  throttle;

  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y,
                  elapsed_us, throttle, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y,
                elapsed_us, throttle, output ready);
endinterface
`default_nettype wire

/* rtl/acf_out_if.sv */
`default_nettype none
interface acf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] roll_angle;
  logic [15:0] pitch_angle;
  logic        motors_off;

  modport source (output valid, roll_angle, pitch_angle, motors_off, input ready);
  modport sink (input valid, roll_angle, pitch_angle, motors_off, output ready);
endinterface
`default_nettype wire

/* rtl/imu_complementary_attitude_filter_top.sv */
`default_nettype none
// a running item passes through 16 cordic steps twice, gain and reload, gyro product, the
// reciprocal divide (init, step, fix), blend and emit before its result is valid
// a held item (throttle below floor) goes from accept straight to emit
// items are taken one at a time: a new item is accepted only in idle, after the last has emitted;
// a new item is taken while the previous result still waits, a stalled result holds emit
// reset: synchronous active-low rst_n clears control, the estimates and loads the register defaults
module imu_complementary_attitude_filter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  acf_in_if.sink           in_ch,
  acf_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // command and status between sequencer and datapath
  acf_pkg::cmd_t cmd;
  acf_pkg::sts_t sts;

  // sequencer: idle, cordic roll pass, gain, cordic pitch pass, gyro, divide, blend, emit
  acf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds registers, cordic, divider, blend and the output register
  acf_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_accel_x      (in_ch.accel_x),
    .in_accel_y      (in_ch.accel_y),
    .in_accel_z      (in_ch.accel_z),
    .in_rate_x       (in_ch.rate_x),
    .in_rate_y       (in_ch.rate_y),
    .in_elapsed_us   (in_ch.elapsed_us),
    .in_throttle     (in_ch.throttle),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_roll_angle  (out_ch.roll_angle),
    .out_pitch_angle (out_ch.pitch_angle),
    .out_motors_off  (out_ch.motors_off)
  );

  // an item is never taken while another is in work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while busy");

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten");

  // result angles stay within half a turn
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      ($signed(out_ch.roll_angle) <= 16'(acf_pkg::ANG_LIM)) &&
      ($signed(out_ch.roll_angle) >= -16'(acf_pkg::ANG_LIM)) &&
      ($signed(out_ch.pitch_angle) <= 16'(acf_pkg::ANG_LIM)) &&
      ($signed(out_ch.pitch_angle) >= -16'(acf_pkg::ANG_LIM)))
    else $error("angle out of range");

endmodule
`default_nettype wire

/* rtl/acf_ctrl.sv */
`default_nettype none
module acf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  acf_pkg::sts_t      sts,
  output acf_pkg::cmd_t      cmd
);

  acf_pkg::state_t state_r, state_nxt;
  logic [acf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  localparam logic [acf_pkg::CNT_W-1:0] CORD_LAST = acf_pkg::CNT_W'(acf_pkg::CORDIC_STEPS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acf_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      acf_pkg::S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = sts.thr_ok ? acf_pkg::S_CORD1 : acf_pkg::S_EMIT;
        end
      end
      acf_pkg::S_CORD1: begin
        if (cnt_r == CORD_LAST) begin
          cnt_nxt   = '0;
          state_nxt = acf_pkg::S_GAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      acf_pkg::S_GAIN:  state_nxt = acf_pkg::S_LOAD2;
      acf_pkg::S_LOAD2: state_nxt = acf_pkg::S_CORD2;
      acf_pkg::S_CORD2: begin
        if (cnt_r == CORD_LAST) begin
          cnt_nxt   = '0;
          state_nxt = acf_pkg::S_GYRO;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      acf_pkg::S_GYRO:    state_nxt = acf_pkg::S_DINIT;
      acf_pkg::S_DINIT:   state_nxt = acf_pkg::S_DIV;
      acf_pkg::S_DIV:     state_nxt = acf_pkg::S_DFIX;
      acf_pkg::S_DFIX:    state_nxt = acf_pkg::S_BLEND_G;
      acf_pkg::S_BLEND_G: state_nxt = acf_pkg::S_BLEND_A;
      acf_pkg::S_BLEND_A: state_nxt = acf_pkg::S_UPDATE;
      acf_pkg::S_UPDATE:  state_nxt = acf_pkg::S_EMIT;
      acf_pkg::S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = acf_pkg::S_IDLE;
        end
      end
      default: state_nxt = acf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.step = cnt_r[acf_pkg::STEP_W-1:0];
    in_ready = 1'b0;
    unique case (state_r)
      acf_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
      end
      acf_pkg::S_CORD1,
      acf_pkg::S_CORD2:   cmd.cord_step = 1'b1;
      acf_pkg::S_GAIN:    cmd.gain      = 1'b1;
      acf_pkg::S_LOAD2:   cmd.load2     = 1'b1;
      acf_pkg::S_GYRO:    cmd.gyro      = 1'b1;
      acf_pkg::S_DINIT:   cmd.div_init  = 1'b1;
      acf_pkg::S_DIV:     cmd.div_step  = 1'b1;
      acf_pkg::S_DFIX:    cmd.div_fix   = 1'b1;
      acf_pkg::S_BLEND_G: cmd.blend_g   = 1'b1;
      acf_pkg::S_BLEND_A: cmd.blend_a   = 1'b1;
      acf_pkg::S_UPDATE:  cmd.update    = 1'b1;
      acf_pkg::S_EMIT:    cmd.emit      = sts.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/acf_dpath.sv */
`default_nettype none
module acf_dpath (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  acf_pkg::cmd_t    cmd,
  output acf_pkg::sts_t    sts,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [15:0] in_accel_x,
  input  wire logic [15:0] in_accel_y,
  input  wire logic [15:0] in_accel_z,
  input  wire logic [15:0] in_rate_x,
  input  wire logic [15:0] in_rate_y,
  input  wire logic [15:0] in_elapsed_us,
  input  wire logic [9:0]  in_throttle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_roll_angle,
  output logic [15:0]      out_pitch_angle,
  output logic             out_motors_off
);

  localparam int CW    = acf_pkg::CW;
  localparam int ZW    = acf_pkg::ZW;
  localparam int EW    = acf_pkg::EW;
  localparam int SH    = acf_pkg::STATE_FRAC - acf_pkg::ANGLE_FRAC_BITS;

  // configuration
  logic [15:0]        alpha_r;
  logic signed [15:0] bias_x_r, bias_y_r;
  logic [9:0]         floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= 16'd64225;
      bias_x_r <= '0;
      bias_y_r <= '0;
      floor_r  <= 10'd10;
    end else if (cfg_we) begin
      unique case (acf_pkg::cfg_idx_t'(cfg_index))
        acf_pkg::CFG_ALPHA:  alpha_r  <= cfg_data;
        acf_pkg::CFG_BIAS_X: bias_x_r <= $signed(cfg_data);
        acf_pkg::CFG_BIAS_Y: bias_y_r <= $signed(cfg_data);
        acf_pkg::CFG_FLOOR:  floor_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [15:0] ax_r, rx_r, ry_r, dt_r;
  logic        off_r;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      ax_r  <= in_accel_x;
      rx_r  <= in_rate_x;
      ry_r  <= in_rate_y;
      dt_r  <= in_elapsed_us;
      off_r <= !sts.thr_ok;
    end
  end

  // shared vectoring cordic
  logic signed [CW-1:0] x_r, y_r, ld_x, ld_y, xs, ys;
  logic signed [ZW-1:0] z_r, atn;
  logic                 zero_r;
  logic [acf_pkg::RMAGW-1:0] rmag_r;

  always_comb begin
    if (cmd.load2) begin
      ld_x = CW'(rmag_r);
      ld_y = -(CW'($signed({ax_r, 14'b0})));
    end else begin
      ld_x = CW'($signed({in_accel_z, 14'b0}));
      ld_y = CW'($signed({in_accel_y, 14'b0}));
    end
    xs  = x_r >>> cmd.step;
    ys  = y_r >>> cmd.step;
    atn = acf_pkg::atan_entry(5'(cmd.step));
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load || cmd.load2) begin
      zero_r <= (ld_x == '0) && (ld_y == '0);
      if (ld_x[CW-1]) begin
        // left half plane: pre-rotate by half a turn
        x_r <= -ld_x;
        y_r <= -ld_y;
        z_r <= ld_y[CW-1] ? -acf_pkg::DEG180 : acf_pkg::DEG180;
      end else begin
        x_r <= ld_x;
        y_r <= ld_y;
        z_r <= '0;
      end
    end else if (cmd.cord_step) begin
      if (!y_r[CW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atn;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atn;
      end
    end
  end

  // gain correction and accelerometer angles
  logic [acf_pkg::MAGW-1:0]               mag;
  logic [acf_pkg::MAGW+acf_pkg::RMAGW-1:0] gprod;
  logic signed [ZW-1:0] roll_meas_r, pitch_meas_r, z_fin;

  assign mag   = zero_r ? '0 : x_r[acf_pkg::MAGW-1:0];
  assign gprod = mag * acf_pkg::INV_GAIN;
  assign z_fin = zero_r ? '0 : z_r;

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      rmag_r      <= gprod[30 +: acf_pkg::RMAGW];
      roll_meas_r <= z_fin;
    end
    if (cmd.gyro) begin
      pitch_meas_r <= z_fin;
    end
  end

  // gyro increments: |rate - bias| * dt, then divide
  logic signed [16:0] rdx, rdy;
  logic [16:0]        absx, absy;
  logic [acf_pkg::PW-1:0] px_r, py_r;
  logic               negx_r, negy_r;

  assign rdx  = 17'($signed(rx_r)) - 17'(bias_x_r);
  assign rdy  = 17'($signed(ry_r)) - 17'(bias_y_r);
  assign absx = rdx[16] ? 17'(-rdx) : 17'(rdx);
  assign absy = rdy[16] ? 17'(-rdy) : 17'(rdy);

  always_ff @(posedge clk) begin
    if (cmd.gyro) begin
      px_r   <= acf_pkg::PW'(absx) * acf_pkg::PW'(dt_r);
      py_r   <= acf_pkg::PW'(absy) * acf_pkg::PW'(dt_r);
      negx_r <= rdx[16];
      negy_r <= rdy[16];
    end
  end

  // division by the constant: reciprocal estimate, remainder, then up to two
  // corrections, both axes side by side
  logic [acf_pkg::NW-1:0]  numx, numy, qdx, qdy;
  logic [acf_pkg::RPW-1:0] rpx, rpy;
  logic [acf_pkg::QW-1:0]  qax_r, qay_r, qx_r, qy_r;
  logic [acf_pkg::RW-1:0]  remx_r, remy_r;
  logic [1:0]              fixx, fixy;

  assign numx = acf_pkg::NW'({px_r, 16'b0}) + acf_pkg::DIV_RND;
  assign numy = acf_pkg::NW'({py_r, 16'b0}) + acf_pkg::DIV_RND;
  assign rpx  = acf_pkg::RPW'(px_r) * acf_pkg::RPW'(acf_pkg::DIV_RECIP);
  assign rpy  = acf_pkg::RPW'(py_r) * acf_pkg::RPW'(acf_pkg::DIV_RECIP);
  assign qdx  = acf_pkg::NW'(qax_r) * acf_pkg::DIV_DEN;
  assign qdy  = acf_pkg::NW'(qay_r) * acf_pkg::DIV_DEN;
  assign fixx = {1'b0, remx_r >= acf_pkg::DIV_DEN1} + {1'b0, remx_r >= acf_pkg::DIV_DEN2};
  assign fixy = {1'b0, remy_r >= acf_pkg::DIV_DEN1} + {1'b0, remy_r >= acf_pkg::DIV_DEN2};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      qax_r <= rpx[acf_pkg::PW +: acf_pkg::QW];
      qay_r <= rpy[acf_pkg::PW +: acf_pkg::QW];
    end
    if (cmd.div_step) begin
      remx_r <= acf_pkg::RW'(numx - qdx);
      remy_r <= acf_pkg::RW'(numy - qdy);
    end
    if (cmd.div_fix) begin
      qx_r <= qax_r + acf_pkg::QW'(fixx);
      qy_r <= qay_r + acf_pkg::QW'(fixy);
    end
  end

  // blend and clamp
  logic signed [EW-1:0] est_x_r, est_y_r;
  logic signed [ZW-1:0] incx, incy, gx, gy;
  logic signed [17:0]   beta;
  logic signed [acf_pkg::GW-1:0] pgx_r, pgy_r;
  logic signed [acf_pkg::AW-1:0] pax_r, pay_r;
  logic signed [acf_pkg::SW-1:0] sumx, sumy, vx, vy;

  assign incx = negx_r ? -$signed(ZW'(qx_r)) : $signed(ZW'(qx_r));
  assign incy = negy_r ? -$signed(ZW'(qy_r)) : $signed(ZW'(qy_r));
  assign gx   = ZW'(est_x_r) + incx;
  assign gy   = ZW'(est_y_r) + incy;
  assign beta = $signed({1'b0, 17'(17'd65536 - {1'b0, alpha_r})});

  assign sumx = acf_pkg::SW'(pgx_r) + acf_pkg::SW'(pax_r) + acf_pkg::SW'(32768);
  assign sumy = acf_pkg::SW'(pgy_r) + acf_pkg::SW'(pay_r) + acf_pkg::SW'(32768);
  assign vx   = sumx >>> acf_pkg::STATE_FRAC;
  assign vy   = sumy >>> acf_pkg::STATE_FRAC;

  function automatic logic signed [EW-1:0] clamp_est(input logic signed [acf_pkg::SW-1:0] v);
    logic signed [EW-1:0] r;
    if (v > acf_pkg::SW'(acf_pkg::DEG180)) begin
      r = EW'(acf_pkg::DEG180);
    end else if (v < -acf_pkg::SW'(acf_pkg::DEG180)) begin
      r = -EW'(acf_pkg::DEG180);
    end else begin
      r = EW'(v);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.blend_g) begin
      pgx_r <= $signed({1'b0, alpha_r}) * gx;
      pgy_r <= $signed({1'b0, alpha_r}) * gy;
    end
    if (cmd.blend_a) begin
      pax_r <= beta * roll_meas_r;
      pay_r <= beta * pitch_meas_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_x_r <= '0;
      est_y_r <= '0;
    end else if (cmd.update) begin
      est_x_r <= clamp_est(vx);
      est_y_r <= clamp_est(vy);
    end
  end

  // output conversion, round half up then saturate to 16 bits
  function automatic logic [15:0] out_angle(input logic signed [EW-1:0] e);
    logic signed [ZW-1:0] t;
    logic [15:0]          r;
    t = (ZW'(e) + ZW'(1 << (SH - 1))) >>> SH;
    if (t > ZW'(32767)) begin
      r = 16'h7fff;
    end else if (t < -ZW'(32768)) begin
      r = 16'h8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  logic        out_valid_r;
  logic [15:0] roll_out_r, pitch_out_r;
  logic        off_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      roll_out_r  <= out_angle(est_x_r);
      pitch_out_r <= out_angle(est_y_r);
      off_out_r   <= off_r;
    end
  end

  assign sts.thr_ok   = in_throttle >= floor_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = roll_out_r;
  assign out_pitch_angle = pitch_out_r;
  assign out_motors_off  = off_out_r;

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;

  // one raw imu sample and one filtered attitude, at the block's widths
  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic [15:0]        dt;
    logic [9:0]         thr;
  } imu_sample_t;

  typedef struct {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic        off;
  } attitude_t;

  // atan(2^-i) in degrees with 16 fraction bits
  localparam longint ATAN_DEG [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };
  localparam longint HALF_TURN = 180 * 65536;
  localparam longint GAIN_COMP = 652032875;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  acf_in_if  in_ch ();
  acf_out_if out_ch ();

  imu_complementary_attitude_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the registers and the two estimates
  logic [15:0]        m_alpha;
  logic signed [15:0] m_bias_x;
  logic signed [15:0] m_bias_y;
  logic [9:0]         m_floor;
  int                 m_roll_est;
  int                 m_pitch_est;

  attitude_t pending_att[$];
  int        n_errors;
  bit        no_idle;   // when set, neither side inserts gaps

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous watchdog, well above the slowest legal run
  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

  // vectoring cordic, returns angle in degrees q.16 and the gained magnitude
  function automatic longint cordic_angle(input longint y_in, input longint x_in,
                                          output longint mag);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    x = x_in;
    y = y_in;
    z = 0;
    mag = 0;
    if (x == 0 && y == 0) return 0;
    // left half plane: rotate by half a turn first
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < acf_pkg::CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_DEG[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_DEG[i];
      end
    end
    mag = x;
    return z;
  endfunction

  // gyro angle step, rounded half away from zero
  function automatic longint gyro_step(input logic signed [15:0] rate,
                                       input logic signed [15:0] bias,
                                       input logic [15:0] dt);
    longint r;
    longint m;
    longint q;
    r = longint'(rate) - longint'(bias);
    m = (r < 0 ? -r : r) * longint'(dt) * 65536;
    q = (m + 65500000) / 131000000;
    return (r < 0) ? -q : q;
  endfunction

  function automatic int fuse_angle(input int est, input longint inc, input longint acc);
    longint g;
    longint a;
    longint v;
    g = longint'(est) + inc;
    a = longint'(m_alpha);
    v = (a * g + (65536 - a) * acc + 32768) >>> acf_pkg::STATE_FRAC;
    if (v > HALF_TURN) v = HALF_TURN;
    if (v < -HALF_TURN) v = -HALF_TURN;
    return int'(v);
  endfunction

  function automatic logic [15:0] to_out_units(input int est);
    longint v;
    int sh;
    sh = acf_pkg::STATE_FRAC - acf_pkg::ANGLE_FRAC_BITS;
    v = (longint'(est) + (longint'(1) << (sh - 1))) >>> sh;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic attitude_t predict_attitude(input imu_sample_t s);
    attitude_t r;
    longint mag;
    longint scratch;
    longint rmag;
    longint roll_meas;
    longint pitch_meas;
    r.off = 1'b1;
    if (s.thr >= m_floor) begin
      roll_meas  = cordic_angle(longint'(s.ay) <<< acf_pkg::PRESCALE,
                                longint'(s.az) <<< acf_pkg::PRESCALE, mag);
      rmag       = (mag * GAIN_COMP) >>> 30;
      pitch_meas = cordic_angle(-(longint'(s.ax) <<< acf_pkg::PRESCALE), rmag, scratch);
      m_roll_est  = fuse_angle(m_roll_est, gyro_step(s.gx, m_bias_x, s.dt), roll_meas);
      m_pitch_est = fuse_angle(m_pitch_est, gyro_step(s.gy, m_bias_y, s.dt), pitch_meas);
      r.off = 1'b0;
    end
    r.roll  = to_out_units(m_roll_est);
    r.pitch = to_out_units(m_pitch_est);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    n_errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // drive one item, wait for accept, then predict it
  task automatic send_sample(input imu_sample_t s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.accel_x    <= s.ax;
    in_ch.accel_y    <= s.ay;
    in_ch.accel_z    <= s.az;
    in_ch.rate_x     <= s.gx;
    in_ch.rate_y     <= s.gy;
    in_ch.elapsed_us <= s.dt;
    in_ch.throttle   <= s.thr;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    pending_att.push_back(predict_attitude(s));
  endtask

  // lower valid and wait until every result is back
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_att.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input acf_pkg::cfg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      acf_pkg::CFG_ALPHA:  m_alpha  = val;
      acf_pkg::CFG_BIAS_X: m_bias_x = val;
      acf_pkg::CFG_BIAS_Y: m_bias_y = val;
      acf_pkg::CFG_FLOOR:  m_floor  = val[9:0];
      default: ;
    endcase
  endtask

  function automatic imu_sample_t make_sample(input int ax, input int ay, input int az,
                                              input int gx, input int gy, input int dt,
                                              input int thr);
    imu_sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az); s.gx = 16'(gx); s.gy = 16'(gy);
    s.dt = 16'(dt); s.thr = 10'(thr);
    return s;
  endfunction

  function automatic imu_sample_t random_sample;
    imu_sample_t s;
    s.ax  = 16'($urandom);
    s.ay  = 16'($urandom);
    s.az  = 16'($urandom);
    s.gx  = 16'($urandom);
    s.gy  = 16'($urandom);
    s.dt  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(500, 5000));
    s.thr = 10'($urandom);
    // some level-ish samples with small axes, and some degenerate ones
    case ($urandom_range(0, 7))
      0: begin s.ay = '0; s.az = '0; end
      1: begin s.ax = '0; s.ay = '0; s.az = '0; end
      2: begin
        s.ax = 16'($urandom_range(0, 4000) - 2000);
        s.ay = 16'($urandom_range(0, 4000) - 2000);
        s.az = 16'(16384 + $urandom_range(0, 2000));
        s.gx = 16'($urandom_range(0, 400) - 200);
        s.gy = 16'($urandom_range(0, 400) - 200);
      end
      default: ;
    endcase
    return s;
  endfunction

  // result side: random stalls, compare against the oldest prediction
  initial begin
    int stall;
    attitude_t want;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      forever begin
        @(posedge clk);
        if (out_ch.valid) break;
      end
      if (pending_att.size() == 0) begin
        flag_mismatch("unexpected item roll_angle", out_ch.roll_angle, 16'd0);
      end else begin
        want = pending_att.pop_front();
        if (out_ch.roll_angle !== want.roll)
          flag_mismatch("roll_angle", out_ch.roll_angle, want.roll);
        if (out_ch.pitch_angle !== want.pitch)
          flag_mismatch("pitch_angle", out_ch.pitch_angle, want.pitch);
        if (out_ch.motors_off !== want.off)
          flag_mismatch("motors_off", {15'd0, out_ch.motors_off}, {15'd0, want.off});
      end
    end
  end

  // extremes, zero vectors, left half plane, held filter
  task automatic test_directed;
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 1023));           // atan2 of zero vector
    send_sample(make_sample(0, 0, 16384, 0, 0, 1000, 500));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 65535, 1023));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, 65535, 1023));
    send_sample(make_sample(0, 100, -16384, 0, 0, 1000, 200));  // az negative, ay positive
    send_sample(make_sample(0, -100, -16384, 0, 0, 1000, 200)); // az negative, ay negative
    send_sample(make_sample(0, 0, -16384, 0, 0, 1000, 200));    // straight down
    send_sample(make_sample(-32768, 0, 0, 0, 0, 1000, 200));
    send_sample(make_sample(32767, 0, 0, 0, 0, 1000, 200));
    send_sample(make_sample(1000, 2000, 3000, 131, -131, 1000, 9));  // below floor, held
    send_sample(make_sample(1000, 2000, 3000, 131, -131, 1000, 10)); // at floor, runs
    send_sample(make_sample(0, 0, 0, 0, 0, 1000, 0));
    send_sample(make_sample(0, 0, 16384, 32767, -32768, 65535, 1023));
    send_sample(make_sample(0, 0, 16384, -32768, 32767, 65535, 1023));
    send_sample(make_sample(0, 0, 16384, 1, -1, 1, 100));
    drain();
  endtask

  // register extremes, each followed by a short burst
  task automatic test_registers;
    write_reg(acf_pkg::CFG_ALPHA, 16'd0);          // accelerometer only
    write_reg(acf_pkg::CFG_FLOOR, 16'd0);          // never held
    repeat (8) send_sample(random_sample());
    drain();
    write_reg(acf_pkg::CFG_ALPHA, 16'hffff);       // gyro nearly only
    write_reg(acf_pkg::CFG_BIAS_X, 16'sh7fff);
    write_reg(acf_pkg::CFG_BIAS_Y, 16'sh8000);
    repeat (10) send_sample(make_sample(0, 0, 16384, -32768, 32767, 65535, 1023));
    repeat (8) send_sample(random_sample());
    drain();
    write_reg(acf_pkg::CFG_BIAS_X, 16'sh8000);
    write_reg(acf_pkg::CFG_BIAS_Y, 16'sh7fff);
    write_reg(acf_pkg::CFG_FLOOR, 16'd1023);       // held unless throttle is full
    repeat (6) send_sample(random_sample());
    send_sample(make_sample(0, 500, 16384, 0, 0, 1000, 1023));
    drain();
    write_reg(acf_pkg::CFG_ALPHA, 16'd64225);
    write_reg(acf_pkg::CFG_BIAS_X, 16'd0);
    write_reg(acf_pkg::CFG_BIAS_Y, 16'd0);
    write_reg(acf_pkg::CFG_FLOOR, 16'd10);
  endtask

  // back-to-back items with no idling on either side
  task automatic test_no_idle;
    no_idle = 1'b1;
    repeat (40) send_sample(random_sample());
    drain();
    no_idle = 1'b0;
  endtask

  // random phases, registers changed between them
  task automatic test_random;
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(acf_pkg::CFG_ALPHA, (ph % 3 == 0) ? 16'($urandom_range(60000, 65535))
                                                  : 16'($urandom));
      write_reg(acf_pkg::CFG_BIAS_X, ($urandom_range(0, 1) != 0)
                                     ? 16'($urandom_range(0, 600) - 300) : 16'($urandom));
      write_reg(acf_pkg::CFG_BIAS_Y, ($urandom_range(0, 1) != 0)
                                     ? 16'($urandom_range(0, 600) - 300) : 16'($urandom));
      write_reg(acf_pkg::CFG_FLOOR, ($urandom_range(0, 3) == 0)
                                    ? 16'($urandom_range(0, 1023))
                                    : 16'($urandom_range(0, 200)));
      no_idle = (ph == 4);
      repeat (45) send_sample(random_sample());
      // sender pauses until every result is back, then resumes
      if (ph == 6) begin
        drain();
        repeat (5) send_sample(random_sample());
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    n_errors    = 0;
    no_idle     = 1'b0;
    m_alpha     = 16'd64225;
    m_bias_x    = '0;
    m_bias_y    = '0;
    m_floor     = 10'd10;
    m_roll_est  = 0;
    m_pitch_est = 0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= acf_pkg::CFG_ALPHA;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.accel_x    <= '0;
    in_ch.accel_y    <= '0;
    in_ch.accel_z    <= '0;
    in_ch.rate_x     <= '0;
    in_ch.rate_y     <= '0;
    in_ch.elapsed_us <= '0;
    in_ch.throttle   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_registers();
    test_no_idle();
    test_random();

    drain();
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* imu_complementary_attitude_filter_top.f */
rtl/acf_pkg.sv
rtl/acf_in_if.sv
rtl/acf_out_if.sv
rtl/acf_ctrl.sv
rtl/acf_dpath.sv
rtl/imu_complementary_attitude_filter_top.sv
tb/sv/tb_top.sv
